### sv/mlst_pkg.sv
package mlst_pkg;

  localparam int MaxLifts  = 8;
  localparam int NumFloors = 128;

  localparam int FloorW = (NumFloors > 1) ? $clog2(NumFloors) : 1;
  localparam int LiftW  = (MaxLifts > 1) ? $clog2(MaxLifts) : 1;
  localparam int TimeW  = 20;
  localparam int SpeedW = 8;
  localparam int XferW  = 8;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [XferW-1:0] XferReset = XferW'(60);

  localparam logic [1:0] ModeSpeed = 2'd0;
  localparam logic [1:0] ModeStop  = 2'd1;
  localparam logic [1:0] ModeSolve = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [2:0]        lift;
    logic [6:0]        floor;
    logic [SpeedW-1:0] speed;
    logic [6:0]        target_floor;
  } in_item_t;

  typedef struct packed {
    logic             reachable;
    logic [TimeW-1:0] total_time;
  } out_item_t;

  // one (lift, floor) search node: reached flag and best time
  typedef struct packed {
    logic             r;
    logic [TimeW-1:0] t;
  } node_t;

  typedef node_t [MaxLifts-1:0] row_t;

endpackage

### sv/mlst_ram.sv
module mlst_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/multi_lift_shortest_time_top.sv
// Multi-lift shortest time solver.
// Input channel (in_valid_i / in_stall_o, in_data_i): a mode 0 request sets a
// lift's seconds per floor, mode 1 adds a stop floor to a lift, mode 2 solves
// for the least time from floor 0 to target_floor. Mode 3 is dropped.
// Output channel (out_valid_o / out_stall_i, out_data_o): one result per
// solve request, none for loads. cfg_we_i writes transfer_time.
// A speed load writes a register; a stop load does a read-modify-write of the
// stop memory. A solve scans the stop memory and clears the search rows, then,
// unless the target is floor 0 or out of range, runs R rounds of an up and a
// down sweep through the node memory (read, candidate, minimum, update and
// carry for each floor), then hands over the answer and clears the stop memory.
// R is the number of sweep rounds until no node time improves, at least 1.
// After reset the stop memory is cleared; in_stall_o is high meanwhile.
// Configuration writes are taken at any time.
// A result is held in an output register; a stall there does not block load
// requests, but the next solve waits to hand over its result until the
// previous one was taken.
module multi_lift_shortest_time_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mlst_pkg::XferW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mlst_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mlst_pkg::out_item_t        out_data_o
);
  import mlst_pkg::*;

  localparam int RowW = $bits(row_t);
  localparam int SumW = TimeW + 1;
  localparam int PtrW = FloorW + 1;
  localparam logic [PtrW-1:0] PtrEnd = PtrW'(NumFloors);
  localparam logic [FloorW-1:0] FloorLast = FloorW'(NumFloors - 1);

  typedef enum logic [13:0] {
    StClr    = 14'b00000000000001,
    StIdle   = 14'b00000000000010,
    StAddRd  = 14'b00000000000100,
    StAddWr  = 14'b00000000001000,
    StScan   = 14'b00000000010000,
    StSeed   = 14'b00000000100000,
    StSwRd   = 14'b00000001000000,
    StSwCand = 14'b00000010000000,
    StSwMin  = 14'b00000100000000,
    StSwUpd  = 14'b00001000000000,
    StSwCarr = 14'b00010000000000,
    StResRd  = 14'b00100000000000,
    StResMin = 14'b01000000000000,
    StResOut = 14'b10000000000000
  } state_e;

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [7:0] b);
    logic [SumW-1:0] s;
    s = {1'b0, a} + SumW'(b);
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

  function automatic node_t row_min(row_t row);
    node_t m;
    m = '0;
    for (int l = 0; l < MaxLifts; l++) begin
      if (row[l].r && (!m.r || row[l].t < m.t)) m = row[l];
    end
    return m;
  endfunction

  state_e state_q, state_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [FloorW-1:0] fl_q, fl_d;
  logic dir_q, dir_d, chg_q, chg_d, rdv_q, rdv_d;
  logic [XferW-1:0] xfer_q;
  logic [SpeedW-1:0] speed_q [MaxLifts];
  logic [1:0] cnt_q [MaxLifts];
  logic [1:0] cnt_d [MaxLifts];
  logic [MaxLifts-1:0] stop0_q, stop0_d, en_q, en_d, active;
  logic [LiftW-1:0] lift_q, lift_d;
  logic [FloorW-1:0] flr_q, flr_d, tgt_q, tgt_d;
  logic tgt_ok_q, tgt_ok_d;
  row_t cand_q, cand_d, old_q, old_d, new_q, new_d, carry_q, carry_d;
  node_t m_q, m_d;
  out_item_t res_q, res_d, out_q;
  logic out_valid_q, out_set;

  logic stop_we, ram_re;
  logic [FloorW-1:0] stop_waddr, raddr, dist_waddr;
  logic [MaxLifts-1:0] stop_wdata, stop_rd;
  logic dist_we;
  row_t dist_wdata, dist_rd;

  logic in_acc;
  logic in_lift_ok, in_floor_ok;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);
  assign in_lift_ok  = (32'(in_data_i.lift) < 32'(MaxLifts));
  assign in_floor_ok = (32'(in_data_i.floor) < 32'(NumFloors));

  always_comb begin
    for (int l = 0; l < MaxLifts; l++) active[l] = cnt_q[l][1];
  end

  mlst_ram #(.Width(MaxLifts), .Depth(NumFloors)) u_stop_ram (
    .clk_i  (clk_i),
    .we_i   (stop_we),
    .waddr_i(stop_waddr),
    .wdata_i(stop_wdata),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(stop_rd)
  );

  mlst_ram #(.Width(RowW), .Depth(NumFloors)) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (dist_we),
    .waddr_i(dist_waddr),
    .wdata_i(dist_wdata),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(dist_rd)
  );

  always_comb begin
    node_t tr_node;
    node_t base;
    logic [TimeW-1:0] tr;
    state_d    = state_q;
    ptr_d      = ptr_q;
    fl_d       = fl_q;
    dir_d      = dir_q;
    chg_d      = chg_q;
    rdv_d      = 1'b0;
    cnt_d      = cnt_q;
    stop0_d    = stop0_q;
    en_d       = en_q;
    lift_d     = lift_q;
    flr_d      = flr_q;
    tgt_d      = tgt_q;
    tgt_ok_d   = tgt_ok_q;
    cand_d     = cand_q;
    old_d      = old_q;
    new_d      = new_q;
    carry_d    = carry_q;
    m_d        = m_q;
    res_d      = res_q;
    out_set    = 1'b0;
    stop_we    = 1'b0;
    stop_waddr = flr_q;
    stop_wdata = '0;
    ram_re     = 1'b0;
    raddr      = fl_q;
    dist_we    = 1'b0;
    dist_waddr = fl_q;
    dist_wdata = '0;
    tr_node    = '0;
    base       = '0;
    tr         = '0;

    unique case (state_q)
      StClr: begin
        stop_we    = 1'b1;
        stop_waddr = ptr_q[FloorW-1:0];
        ptr_d      = ptr_q + 1'b1;
        if (ptr_q == PtrW'(NumFloors - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (in_acc) begin
          lift_d = in_data_i.lift[LiftW-1:0];
          flr_d  = FloorW'(in_data_i.floor);
          tgt_d  = FloorW'(in_data_i.target_floor);
          tgt_ok_d = (32'(in_data_i.target_floor) < 32'(NumFloors));
          priority case (in_data_i.mode)
            ModeStop: begin
              if (in_lift_ok && in_floor_ok) state_d = StAddRd;
            end
            ModeSolve: begin
              ptr_d = '0;
              for (int l = 0; l < MaxLifts; l++) cnt_d[l] = '0;
              state_d = StScan;
            end
            default: ;
          endcase
        end
      end
      StAddRd: begin
        ram_re  = 1'b1;
        raddr   = flr_q;
        state_d = StAddWr;
      end
      StAddWr: begin
        stop_we    = 1'b1;
        stop_waddr = flr_q;
        stop_wdata = stop_rd;
        stop_wdata[lift_q] = 1'b1;
        state_d    = StIdle;
      end
      StScan: begin
        // count stops per lift (saturating at 2) and clear the node rows
        if (ptr_q != PtrEnd) begin
          ram_re     = 1'b1;
          raddr      = ptr_q[FloorW-1:0];
          dist_we    = 1'b1;
          dist_waddr = ptr_q[FloorW-1:0];
          ptr_d      = ptr_q + 1'b1;
          rdv_d      = 1'b1;
        end
        if (rdv_q) begin
          for (int l = 0; l < MaxLifts; l++) begin
            if (stop_rd[l] && !cnt_q[l][1]) cnt_d[l] = cnt_q[l] + 2'd1;
          end
          if (ptr_q == PtrW'(1)) stop0_d = stop_rd;
        end
        if (ptr_q == PtrEnd && !rdv_q) begin
          if (!tgt_ok_q) begin
            res_d   = '0;
            state_d = StResOut;
          end else if (tgt_q == '0) begin
            res_d.reachable  = |stop0_q;
            res_d.total_time = '0;
            state_d = StResOut;
          end else begin
            state_d = StSeed;
          end
        end
      end
      StSeed: begin
        dist_we    = 1'b1;
        dist_waddr = '0;
        for (int l = 0; l < MaxLifts; l++) begin
          dist_wdata[l].r = stop0_q[l] && active[l];
        end
        fl_d    = '0;
        dir_d   = 1'b0;
        chg_d   = 1'b0;
        carry_d = '0;
        state_d = StSwRd;
      end
      StSwRd: begin
        ram_re  = 1'b1;
        raddr   = fl_q;
        state_d = StSwCand;
      end
      StSwCand: begin
        // merge the ride arriving from the previous floor into each stop node
        for (int l = 0; l < MaxLifts; l++) begin
          en_d[l]  = stop_rd[l] && active[l];
          old_d[l] = dist_rd[l];
          cand_d[l] = '0;
          if (en_d[l]) begin
            if (carry_q[l].r && (!dist_rd[l].r || carry_q[l].t < dist_rd[l].t))
              cand_d[l] = carry_q[l];
            else
              cand_d[l] = dist_rd[l];
          end
        end
        state_d = StSwMin;
      end
      StSwMin: begin
        m_d     = row_min(cand_q);
        state_d = StSwUpd;
      end
      StSwUpd: begin
        tr = sat_add(m_q.t, xfer_q);
        tr_node.r = 1'b1;
        tr_node.t = tr;
        for (int l = 0; l < MaxLifts; l++) begin
          new_d[l] = cand_q[l];
          if (en_q[l] && m_q.r && (!cand_q[l].r || tr < cand_q[l].t)) new_d[l] = tr_node;
          if (en_q[l] && new_d[l].r && (!old_q[l].r || new_d[l].t < old_q[l].t))
            chg_d = 1'b1;
        end
        dist_we    = 1'b1;
        dist_waddr = fl_q;
        dist_wdata = new_d;
        state_d    = StSwCarr;
      end
      StSwCarr: begin
        for (int l = 0; l < MaxLifts; l++) begin
          base = en_q[l] ? new_q[l] : carry_q[l];
          carry_d[l].r = base.r;
          carry_d[l].t = base.r ? sat_add(base.t, speed_q[l]) : '0;
        end
        state_d = StSwRd;
        if (!dir_q) begin
          if (fl_q == FloorLast) begin
            dir_d   = 1'b1;
            carry_d = '0;
          end else begin
            fl_d = fl_q + 1'b1;
          end
        end else begin
          if (fl_q == '0) begin
            if (chg_q) begin
              dir_d   = 1'b0;
              chg_d   = 1'b0;
              carry_d = '0;
            end else begin
              state_d = StResRd;
            end
          end else begin
            fl_d = fl_q - 1'b1;
          end
        end
      end
      StResRd: begin
        ram_re  = 1'b1;
        raddr   = tgt_q;
        state_d = StResMin;
      end
      StResMin: begin
        m_d              = row_min(dist_rd);
        res_d.reachable  = m_d.r;
        res_d.total_time = m_d.r ? m_d.t : '0;
        state_d          = StResOut;
      end
      StResOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_set = 1'b1;
          ptr_d   = '0;
          state_d = StClr;
        end
      end
      default: state_d = StClr;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      ptr_q       <= '0;
      fl_q        <= '0;
      dir_q       <= 1'b0;
      chg_q       <= 1'b0;
      rdv_q       <= 1'b0;
      xfer_q      <= XferReset;
      out_valid_q <= 1'b0;
      for (int l = 0; l < MaxLifts; l++) begin
        speed_q[l] <= '0;
        cnt_q[l]   <= '0;
      end
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      fl_q    <= fl_d;
      dir_q   <= dir_d;
      chg_q   <= chg_d;
      rdv_q   <= rdv_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) xfer_q <= cfg_wdata_i;
      if (in_acc && in_data_i.mode == ModeSpeed && in_lift_ok) begin
        speed_q[in_data_i.lift[LiftW-1:0]] <= in_data_i.speed;
      end
      if (out_set) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    stop0_q  <= stop0_d;
    en_q     <= en_d;
    lift_q   <= lift_d;
    flr_q    <= flr_d;
    tgt_q    <= tgt_d;
    tgt_ok_q <= tgt_ok_d;
    cand_q   <= cand_d;
    old_q    <= old_d;
    new_q    <= new_d;
    carry_q  <= carry_d;
    m_q      <= m_d;
    res_q    <= res_d;
    if (out_set) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_rise_from_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StResOut))
    else $error("result raised outside the answer state");

  a_res_then_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StResOut && (!out_valid_q || !out_stall_i)) |=> (state_q == StClr))
    else $error("stop memory not cleared after a solve");

  a_add_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAddWr) |-> $past(state_q == StAddRd))
    else $error("stop write without a preceding read");

endmodule
